/* rtl/core/magma_pkg.sv */
// Shared constants, tables and round function of the Magma block cipher core.
`default_nettype none

package magma_pkg;

   localparam int unsigned ROUNDS     = 32;
   localparam int unsigned ASC_ROUNDS = 24;
   localparam int unsigned ROT_AMT    = 11;
   localparam int unsigned KEY_WORDS  = 8;
   localparam int unsigned HALF_W     = 32;
   localparam int unsigned BLOCK_W    = 64;
   localparam int unsigned KEY_IDX_W  = $clog2(KEY_WORDS);

   typedef logic [HALF_W-1:0]    half_type;
   typedef logic [KEY_IDX_W-1:0] key_idx_type;
   typedef logic [3:0]           nibble_type;

   // Operation codes carried in tuser.
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // Standard test key, word 0 is the most significant part.
   localparam half_type KEY_RESET [KEY_WORDS] = '{
      32'hffeeddcc, 32'hbbaa9988, 32'h77665544, 32'h33221100,
      32'hf0f1f2f3, 32'hf4f5f6f7, 32'hf8f9fafb, 32'hfcfdfeff
   };

   // Eight 4-bit substitution boxes, box n serves nibble n from the bottom.
   localparam nibble_type SBOX [8][16] = '{
      '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
        4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
      '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
        4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
      '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
        4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
      '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
        4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
      '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
        4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
      '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
        4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
      '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
        4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
      '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
        4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
   };

   // Key word used by encryption round r: 0..7 three times, then 7..0.
   function automatic key_idx_type enc_key_idx(input int unsigned r);
      int unsigned k;
      if (r < ASC_ROUNDS) begin
         k = r % KEY_WORDS;
      end else begin
         k = KEY_WORDS - 1 - (r % KEY_WORDS);
      end
      return key_idx_type'(k);
   endfunction

   // Decryption runs the same schedule backwards.
   function automatic key_idx_type dec_key_idx(input int unsigned r);
      return enc_key_idx(ROUNDS - 1 - r);
   endfunction

   // Round function: add key mod 2^32, substitute nibbles, rotate left by 11.
   function automatic half_type round_mix(input half_type half, input half_type rk);
      half_type sum;
      half_type sub;
      sum = half + rk;
      sub = '0;
      for (int n = 0; n < 8; n++) begin
         sub[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
      end
      return {sub[HALF_W-1-ROT_AMT:0], sub[HALF_W-1:HALF_W-ROT_AMT]};
   endfunction

endpackage

`default_nettype wire

/* rtl/core/magma_block_cipher_unit.sv */
// Top level of the Magma block cipher core: a 32-stage round pipeline with stream ports.
// Path: an accepted block passes through the stage registers in order, from stage 0 to
// stage 31, one Feistel round per register stage, and is then offered on rsp_.
// Throughput: one block per cycle while rsp_ is not stalled; each stage moves on its own, so bubbles close up
// and a stalled output holds only the stages behind it that are full.
// Reset: synchronous, active high; empties the pipeline and loads the standard test key.
`default_nettype none

module magma_block_cipher_unit
   import magma_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Input block stream.
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [BLOCK_W-1:0]   req_tdata,   // [63:0] block_in
   input  wire logic                 req_tuser,   // [0] kind (0 encrypt, 1 decrypt)
   // Result block stream.
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [BLOCK_W-1:0]        rsp_tdata,   // [63:0] block_out
   // Key register writes.
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [KEY_IDX_W-1:0] csr_index,
   input  wire logic [HALF_W-1:0]    csr_data
);

   // Key registers.
   half_type key_ff [KEY_WORDS];

   // Pipeline stage registers, stage g holds the halves after round g.
   logic     vld_ff  [ROUNDS];
   logic     kind_ff [ROUNDS];
   half_type hi_ff   [ROUNDS];
   half_type lo_ff   [ROUNDS];

   // Next values and per-stage load enables.
   logic     stage_rdy [ROUNDS];
   logic     vld_in    [ROUNDS];
   logic     kind_in   [ROUNDS];
   half_type hi_in     [ROUNDS];
   half_type lo_in     [ROUNDS];

   // Key writes are always taken; indexes cover exactly the eight words.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= KEY_RESET[i];
         end
      end else if (csr_valid && csr_ready) begin
         key_ff[csr_index] <= csr_data;
      end
   end

   // A stage can load when it is empty or its content moves on this cycle.
   assign stage_rdy[ROUNDS-1] = !vld_ff[ROUNDS-1] || rsp_tready;

   generate
      for (genvar g = 0; g < ROUNDS - 1; g++) begin : g_rdy
         assign stage_rdy[g] = !vld_ff[g] || stage_rdy[g+1];
      end
   endgenerate

   assign req_tready = stage_rdy[0];

   // One Feistel round per stage.
   generate
      for (genvar g = 0; g < ROUNDS; g++) begin : g_stage
         localparam key_idx_type ENC_IDX = enc_key_idx(g);
         localparam key_idx_type DEC_IDX = dec_key_idx(g);

         logic     src_vld;
         logic     src_kind;
         half_type src_hi;
         half_type src_lo;
         half_type rk;

         if (g == 0) begin : g_first
            assign src_vld  = req_tvalid;
            assign src_kind = req_tuser;
            assign src_hi   = req_tdata[BLOCK_W-1:HALF_W];
            assign src_lo   = req_tdata[HALF_W-1:0];
         end else begin : g_next
            assign src_vld  = vld_ff[g-1];
            assign src_kind = kind_ff[g-1];
            assign src_hi   = hi_ff[g-1];
            assign src_lo   = lo_ff[g-1];
         end

         // Round key picked by operation.
         assign rk = (src_kind == OP_DECRYPT) ? key_ff[DEC_IDX] : key_ff[ENC_IDX];

         always_comb begin
            vld_in[g]  = src_vld;
            kind_in[g] = src_kind;
            hi_in[g]   = src_lo;
            lo_in[g]   = src_hi ^ round_mix(src_lo, rk);
         end

         // Valid bit is control state; the halves are payload.
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[g] <= 1'b0;
            end else if (stage_rdy[g]) begin
               vld_ff[g] <= vld_in[g];
            end
         end

         always_ff @(posedge clock) begin
            if (stage_rdy[g] && vld_in[g]) begin
               kind_ff[g] <= kind_in[g];
               hi_ff[g]   <= hi_in[g];
               lo_ff[g]   <= lo_in[g];
            end
         end
      end
   endgenerate

   // Last round is unswapped: the newest half goes on top.
   assign rsp_tvalid = vld_ff[ROUNDS-1];
   assign rsp_tdata  = {lo_ff[ROUNDS-1], hi_ff[ROUNDS-1]};

`ifndef SYNTHESIS
   // An empty output stage lets the whole ready chain through.
   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output stage is empty");

   // A taken output always frees the input side.
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output is being drained");

   // An accepted block occupies the first stage on the next cycle.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted block missing from first stage");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");
`endif

endmodule

`default_nettype wire
